// ===== hdl/ctp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared result types and output kind codes for the Content-Type parser.
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam logic [2:0] KIND_MAJOR = 3'd0;
    localparam logic [2:0] KIND_NAME  = 3'd1;
    localparam logic [2:0] KIND_VALUE = 3'd2;
    localparam logic [2:0] KIND_PARAM = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    localparam int MaxResults = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_char;
        logic       halted;
        logic       last_of_run;
    } result_t;

    // All results caused by one character, first result in slot 0.
    typedef struct packed {
        result_t [MaxResults-1:0] res;
        logic    [1:0]            cnt;
    } burst_t;

endpackage : ctp_pkg
`default_nettype wire

// ===== hdl/ctp_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_in_if
// Character request channel: one header-value character per request.
// ----------------------------------------------------------------------------
interface ctp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_value;

    modport source (output valid, output ch, output end_of_value, input ready);
    modport sink   (input valid, input ch, input end_of_value, output ready);
endinterface : ctp_in_if
`default_nettype wire

// ===== hdl/ctp_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_out_if
// Result request channel: one tagged character or marker per request.
// ----------------------------------------------------------------------------
interface ctp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_char;
    logic       halted;
    logic       last_of_run;

    modport source (output valid, output kind, output out_char, output halted,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_char, input halted,
                    input last_of_run, output ready);
endinterface : ctp_out_if
`default_nettype wire

// ===== hdl/content_type_header_parser.sv =====
// A result is offered from the result register, which is loaded when its character is accepted.
// Throughput: one character per cycle while each character causes at most one result and
// results are taken at once; a character causing several results holds the input until its
// last result is being taken, as the single read port of the result register hands them out
// one at a time. Reset: parse state returns to start of value and the result register empties.
`default_nettype none
// ----------------------------------------------------------------------------
// content_type_header_parser
// Streaming parser for Content-Type style header values, one character per
// request, giving tagged characters, parameter markers and a done marker.
// ----------------------------------------------------------------------------
module content_type_header_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ctp_in_if.sink     item,
    ctp_out_if.source  result
);
    import ctp_pkg::*;

    // The parser works straight on the incoming request. Its state moves on
    // only when the request is accepted, and every result it produces for
    // that character is captured together in the result register.
    burst_t  burst;
    result_t head;
    logic    can_load;
    logic    accept;

    // A new request is taken whenever the result register is free or is
    // handing out its final pending result in this cycle, so a stream of
    // single-result characters flows at full rate while the results are
    // being taken.
    assign item.ready = can_load;
    assign accept     = item.valid && can_load;

    ctp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .ch           (item.ch),
        .end_of_value (item.end_of_value),
        .burst        (burst)
    );

    // Characters that cause no result (spaces, separators, quotes, the
    // escape character) still load the register, with a count of zero.
    ctp_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .burst     (burst),
        .can_load  (can_load),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (head)
    );

    assign result.kind        = head.kind;
    assign result.out_char    = head.out_char;
    assign result.halted      = head.halted;
    assign result.last_of_run = head.last_of_run;

endmodule : content_type_header_parser
`default_nettype wire

// ===== hdl/ctp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_parser
// Parse state machine: classifies one character and lists its results.
// ----------------------------------------------------------------------------
module ctp_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      ch,
    input  wire logic            end_of_value,
    output ctp_pkg::burst_t      burst
);
    import ctp_pkg::*;

    typedef enum logic [3:0] {
        PS_START, PS_MAJOR, PS_MAJOR_SP, PS_SEMI, PS_NAME,
        PS_NAME_SP, PS_EQ, PS_VALUE, PS_ESC, PS_HALT
    } pstate_t;

    typedef enum logic [1:0] {
        Q_NONE, Q_SINGLE, Q_DOUBLE
    } quote_t;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    pstate_t    state_reg, state_next;
    quote_t     quote_reg, quote_next;
    logic       is_sp, is_gr, is_an;
    logic       m_valid, f_valid;
    logic [2:0] m_kind;
    logic       done_halted;
    result_t    m_res, f_res, d_res;
    logic [1:0] n;

    assign is_sp = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    assign is_gr = (ch >= 8'h21) && (ch <= 8'h7E);
    assign is_an = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A)
                || (ch >= 8'h61 && ch <= 8'h7A);

    always_comb
    begin
        state_next  = state_reg;
        quote_next  = quote_reg;
        m_valid     = 1'b0;
        m_kind      = KIND_MAJOR;
        f_valid     = 1'b0;
        done_halted = 1'b0;
        case (state_reg)
            PS_START:
            begin
                if (is_sp) state_next = PS_START;
                else if (ch == CH_SEMI) state_next = PS_SEMI;
                else if (is_gr)
                begin
                    m_valid    = 1'b1;
                    state_next = PS_MAJOR;
                end
                else state_next = PS_HALT;
            end
            PS_MAJOR:
            begin
                if (is_sp) state_next = PS_MAJOR_SP;
                else if (ch == CH_SEMI) state_next = PS_SEMI;
                else if (is_gr) m_valid = 1'b1;
                else state_next = PS_HALT;
            end
            PS_MAJOR_SP:
            begin
                if (is_sp) state_next = PS_MAJOR_SP;
                else if (ch == CH_SEMI) state_next = PS_SEMI;
                else state_next = PS_HALT;
            end
            PS_SEMI:
            begin
                if (is_sp || ch == CH_SEMI) state_next = PS_SEMI;
                else if (is_an || ch == CH_UNDER)
                begin
                    m_valid    = 1'b1;
                    m_kind     = KIND_NAME;
                    state_next = PS_NAME;
                end
                else state_next = PS_HALT;
            end
            PS_NAME:
            begin
                if (is_sp) state_next = PS_NAME_SP;
                else if (ch == CH_EQ) state_next = PS_EQ;
                else if (is_an || ch == CH_UNDER || ch == CH_DOT || ch == CH_DASH)
                begin
                    m_valid = 1'b1;
                    m_kind  = KIND_NAME;
                end
                else state_next = PS_HALT;
            end
            PS_NAME_SP:
            begin
                if (is_sp) state_next = PS_NAME_SP;
                else if (ch == CH_EQ) state_next = PS_EQ;
                else state_next = PS_HALT;
            end
            PS_EQ:
            begin
                if (is_sp) state_next = PS_EQ;
                else if (ch == CH_DQUOTE)
                begin
                    quote_next = Q_DOUBLE;
                    state_next = PS_VALUE;
                end
                else if (ch == CH_SQUOTE)
                begin
                    quote_next = Q_SINGLE;
                    state_next = PS_VALUE;
                end
                else
                begin
                    m_valid    = 1'b1;
                    m_kind     = KIND_VALUE;
                    quote_next = Q_NONE;
                    state_next = PS_VALUE;
                end
            end
            PS_VALUE:
            begin
                if ((ch == CH_DQUOTE && quote_reg == Q_DOUBLE)
                    || (ch == CH_SQUOTE && quote_reg == Q_SINGLE)
                    || (ch == CH_SEMI && quote_reg == Q_NONE))
                begin
                    m_valid    = 1'b1;
                    m_kind     = KIND_PARAM;
                    state_next = PS_SEMI;
                end
                else if (ch == CH_BSLASH && quote_reg != Q_NONE)
                begin
                    state_next = PS_ESC;
                end
                else
                begin
                    m_valid = 1'b1;
                    m_kind  = KIND_VALUE;
                end
            end
            PS_ESC:
            begin
                m_valid    = 1'b1;
                m_kind     = KIND_VALUE;
                state_next = PS_VALUE;
            end
            default: state_next = PS_HALT;
        endcase

        // The last character closes any open parameter and ends the value.
        if (end_of_value)
        begin
            f_valid     = state_next inside {PS_EQ, PS_VALUE, PS_ESC};
            done_halted = (state_next == PS_HALT);
            state_next  = PS_START;
            quote_next  = Q_NONE;
        end
    end

    always_comb
    begin
        m_res.kind        = m_kind;
        m_res.out_char    = (m_kind == KIND_PARAM) ? 8'h00 : ch;
        m_res.halted      = 1'b0;
        m_res.last_of_run = 1'b0;
        f_res.kind        = KIND_PARAM;
        f_res.out_char    = 8'h00;
        f_res.halted      = 1'b0;
        f_res.last_of_run = 1'b0;
        d_res.kind        = KIND_DONE;
        d_res.out_char    = 8'h00;
        d_res.halted      = done_halted;
        d_res.last_of_run = 1'b0;

        burst = '0;
        n     = 2'd0;
        if (m_valid)
        begin
            burst.res[n] = m_res;
            n            = n + 2'd1;
        end
        if (f_valid)
        begin
            burst.res[n] = f_res;
            n            = n + 2'd1;
        end
        if (end_of_value)
        begin
            burst.res[n] = d_res;
            n            = n + 2'd1;
        end
        if (n != 2'd0)
        begin
            burst.res[n - 2'd1].last_of_run = 1'b1;
        end
        burst.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_START;
            quote_reg <= Q_NONE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            quote_reg <= quote_next;
        end
    end

endmodule : ctp_parser
`default_nettype wire

// ===== hdl/ctp_resq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_resq
// Result register: holds the results of one character and hands them out
// one per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module ctp_resq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire ctp_pkg::burst_t burst,
    output logic                 can_load,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ctp_pkg::result_t     out_res
);
    import ctp_pkg::*;

    result_t [MaxResults-1:0] slots_reg;
    logic    [1:0]            cnt_reg, cnt_next;
    logic    [1:0]            rd_reg, rd_next;
    logic                     take;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = slots_reg[rd_reg];
    assign take      = out_valid && out_ready;
    // Empty, or the final pending result leaves in this cycle.
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load)
        begin
            cnt_next = burst.cnt;
            rd_next  = 2'd0;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 2'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slots_reg <= burst.res;
        end
    end

endmodule : ctp_resq
`default_nettype wire

// ===== verif/tb_content_type_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_content_type_header_parser
// Self-checking bench for the Content-Type parser. A short table of directed
// characters opens the run, followed by randomly built header values, most of
// them well formed and some corrupted or cut short. A behavioural copy of the
// parser predicts the results, except where a directed row types its own. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_content_type_header_parser;

    import ctp_pkg::*;

    // Parse states of the behavioural copy. Halted absorbs everything that
    // follows a syntax error until the end of the value.
    localparam logic [3:0] PS_START       = 4'd0;
    localparam logic [3:0] PS_MAJOR       = 4'd1;
    localparam logic [3:0] PS_MAJOR_WS    = 4'd2;
    localparam logic [3:0] PS_PARAM_GAP   = 4'd3;
    localparam logic [3:0] PS_NAME        = 4'd4;
    localparam logic [3:0] PS_NAME_WS     = 4'd5;
    localparam logic [3:0] PS_VALUE_START = 4'd6;
    localparam logic [3:0] PS_VALUE       = 4'd7;
    localparam logic [3:0] PS_ESCAPE      = 4'd8;
    localparam logic [3:0] PS_HALT        = 4'd9;

    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_SINGLE = 2'd1;
    localparam logic [1:0] Q_DOUBLE = 2'd2;

    // Characters with a syntactic meaning.
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int NUM_DIRECTED = 26;
    localparam int TARGET_CHARS = 260;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [7:0] c;
        logic       eov;
        int         n_typed;    // -1: take the prediction, else results typed below
        result_t    typed_res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ctp_in_if  item_bus ();
    ctp_out_if result_bus ();

    content_type_header_parser DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // State of the behavioural copy of the parser.
    logic [3:0] parse_st  = PS_START;
    logic [1:0] quote_md  = Q_NONE;

    result_t    expected_results[$];
    int         mismatch_count = 0;
    int         active_chars   = 0;
    bit         steady_flow    = 1'b0;
    dir_row_t   dir_tab[NUM_DIRECTED];

    // ------------------------------------------------------------------------
    // Character classes, ASCII only: bytes from 0x80 up belong to none.
    // ------------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_graphic(logic [7:0] c);
        return (c >= 8'h21) && (c <= 8'h7E);
    endfunction

    function automatic bit is_alnum(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic result_t mk_result(logic [2:0] k, logic [7:0] c, logic h, logic l);
        result_t r;
        r.kind        = k;
        r.out_char    = c;
        r.halted      = h;
        r.last_of_run = l;
        return r;
    endfunction

    function automatic burst_t with_result(burst_t b, logic [2:0] k, logic [7:0] c, logic h);
        burst_t nb;
        nb = b;
        nb.res[nb.cnt] = mk_result(k, c, h, 1'b0);
        nb.cnt = nb.cnt + 2'd1;
        return nb;
    endfunction

    // ------------------------------------------------------------------------
    // Behavioural parser: takes one character, advances its own state and
    // returns the results that the character causes, first in slot 0.
    // ------------------------------------------------------------------------
    function automatic burst_t parse_char(logic [7:0] c, logic eov);
        burst_t     b;
        logic [3:0] s;
        logic [1:0] q;
        b = '0;
        s = parse_st;
        q = quote_md;
        case (s)
            PS_START:
                if (!is_space(c))
                begin
                    if (c == CH_SEMI)
                        s = PS_PARAM_GAP;
                    else if (is_graphic(c))
                    begin
                        b = with_result(b, KIND_MAJOR, c, 1'b0);
                        s = PS_MAJOR;
                    end
                    else
                        s = PS_HALT;
                end
            PS_MAJOR:
                if (is_space(c))
                    s = PS_MAJOR_WS;
                else if (c == CH_SEMI)
                    s = PS_PARAM_GAP;
                else if (is_graphic(c))
                    b = with_result(b, KIND_MAJOR, c, 1'b0);
                else
                    s = PS_HALT;
            PS_MAJOR_WS:
                if (!is_space(c))
                    s = (c == CH_SEMI) ? PS_PARAM_GAP : PS_HALT;
            PS_PARAM_GAP:
                if (!is_space(c) && c != CH_SEMI)
                begin
                    if (is_alnum(c) || c == CH_USCORE)
                    begin
                        b = with_result(b, KIND_NAME, c, 1'b0);
                        s = PS_NAME;
                    end
                    else
                        s = PS_HALT;
                end
            PS_NAME:
                if (is_space(c))
                    s = PS_NAME_WS;
                else if (c == CH_EQ)
                    s = PS_VALUE_START;
                else if (is_alnum(c) || c == CH_USCORE || c == CH_DOT || c == CH_DASH)
                    b = with_result(b, KIND_NAME, c, 1'b0);
                else
                    s = PS_HALT;
            PS_NAME_WS:
                if (!is_space(c))
                    s = (c == CH_EQ) ? PS_VALUE_START : PS_HALT;
            PS_VALUE_START:
                if (c == CH_DQUOTE)
                begin
                    q = Q_DOUBLE;
                    s = PS_VALUE;
                end
                else if (c == CH_SQUOTE)
                begin
                    q = Q_SINGLE;
                    s = PS_VALUE;
                end
                else if (!is_space(c))
                begin
                    b = with_result(b, KIND_VALUE, c, 1'b0);
                    q = Q_NONE;
                    s = PS_VALUE;
                end
            PS_VALUE:
                if ((c == CH_DQUOTE && q == Q_DOUBLE) || (c == CH_SQUOTE && q == Q_SINGLE) ||
                    (c == CH_SEMI && q == Q_NONE))
                begin
                    b = with_result(b, KIND_PARAM, 8'h00, 1'b0);
                    s = PS_PARAM_GAP;
                end
                else if (c == CH_BSLASH && q != Q_NONE)
                    s = PS_ESCAPE;
                else
                    b = with_result(b, KIND_VALUE, c, 1'b0);
            PS_ESCAPE:
            begin
                b = with_result(b, KIND_VALUE, c, 1'b0);
                s = PS_VALUE;
            end
            default:
                s = PS_HALT;
        endcase

        // The final character flushes an open parameter and closes the value.
        if (eov)
        begin
            if (s == PS_VALUE_START || s == PS_VALUE || s == PS_ESCAPE)
                b = with_result(b, KIND_PARAM, 8'h00, 1'b0);
            b = with_result(b, KIND_DONE, 8'h00, s >= PS_HALT);
            s = PS_START;
            q = Q_NONE;
        end

        if (b.cnt != 2'd0)
            b.res[b.cnt - 2'd1].last_of_run = 1'b1;
        parse_st = s;
        quote_md = q;
        return b;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    function automatic logic [7:0] ws_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'h09 + r[7:0];
    endfunction

    // A legal parameter-name character; only later ones may be a dot or dash.
    function automatic logic [7:0] name_char(bit first);
        int r;
        r = $urandom_range(0, first ? 62 : 64);
        if (r < 10)
            return "0" + r[7:0];
        else if (r < 36)
            return "A" + r[7:0] - 8'd10;
        else if (r < 62)
            return "a" + r[7:0] - 8'd36;
        else if (r == 62)
            return CH_USCORE;
        else if (r == 63)
            return CH_DOT;
        else
            return CH_DASH;
    endfunction

    function automatic dir_row_t dir_row(logic [7:0] c, logic eov, int n, result_t r);
        dir_row_t d;
        d.c         = c;
        d.eov       = eov;
        d.n_typed   = n;
        d.typed_res = r;
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and the single reset at the start of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Character side. A request is left on the bus after it is taken, so the
    // caller must follow it in the same time step with the next request or
    // lower valid. A gap lowers valid only when it is longer than zero.
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic eov, input int n_typed,
                             input result_t typed_res);
        int     gap;
        burst_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.ch           <= c;
        item_bus.end_of_value <= eov;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);

        predicted = parse_char(c, eov);
        active_chars++;

        if (n_typed < 0)
        begin
            for (int k = 0; k < predicted.cnt; k++)
                expected_results = {expected_results, predicted.res[k]};
        end
        else if (n_typed > 0)
            expected_results = {expected_results, typed_res};
    endtask

    // Holds off the sender until every result already owed has come back.
    // It always lowers valid first, even when nothing is owed.
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // One random header value. Most are well formed with random content: a
    // major token, mostly present, then parameters whose values are unquoted,
    // double-quoted or single-quoted with escapes. Some are pure noise, some have
    // one character corrupted and some are cut short at a random point.
    // ------------------------------------------------------------------------
    task automatic send_header_value();
        logic [7:0] seq[$];
        logic [7:0] c;
        logic [7:0] closing;
        int         style;
        int         len;
        int         idx;
        int         mode;
        style = $urandom_range(0, 9);
        if (style == 0)
        begin
            len = $urandom_range(1, 6);
            repeat (len) seq = {seq, 8'($urandom_range(0, 255))};
        end
        else
        begin
            if ($urandom_range(0, 5) == 0)
                seq = {seq, ws_char()};
            // A value may also open straight on a parameter with no major token.
            if ($urandom_range(0, 9) != 0)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    c = 8'($urandom_range(8'h21, 8'h7E));
                    seq = {seq, ((c == CH_SEMI) ? 8'h2F : c)};
                end
                if ($urandom_range(0, 3) == 0)
                    seq = {seq, ws_char()};
            end
            repeat ($urandom_range(0, 3))
            begin
                seq = {seq, CH_SEMI};
                if ($urandom_range(0, 3) == 0)
                    seq = {seq, ws_char()};
                seq = {seq, name_char(1'b1)};
                repeat ($urandom_range(0, 3)) seq = {seq, name_char(1'b0)};
                if ($urandom_range(0, 4) == 0)
                    seq = {seq, ws_char()};
                seq = {seq, CH_EQ};
                if ($urandom_range(0, 4) == 0)
                    seq = {seq, ws_char()};
                mode = $urandom_range(0, 2);
                if (mode == 0)
                begin
                    // Unquoted: the next semicolon closes the parameter.
                    c = 8'($urandom_range(0, 255));
                    if (is_space(c) || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_SEMI)
                        c = "v";
                    seq = {seq, c};
                    repeat ($urandom_range(0, 4))
                    begin
                        c = 8'($urandom_range(0, 255));
                        seq = {seq, ((c == CH_SEMI) ? 8'("w") : c)};
                    end
                end
                else
                begin
                    closing = (mode == 1) ? CH_DQUOTE : CH_SQUOTE;
                    seq = {seq, closing};
                    repeat ($urandom_range(0, 5))
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            seq = {seq, CH_BSLASH};
                            seq = {seq, 8'($urandom_range(0, 255))};
                        end
                        else
                        begin
                            c = 8'($urandom_range(0, 255));
                            seq = {seq, ((c == closing || c == CH_BSLASH) ? 8'("q") : c)};
                        end
                    end
                    seq = {seq, closing};
                    if ($urandom_range(0, 4) == 0)
                        seq = {seq, ws_char()};
                end
            end
            if (seq.size() == 0)
                seq = {seq, 8'("x")};
            if (style == 1)
            begin
                idx = $urandom_range(0, seq.size() - 1);
                seq[idx] = 8'($urandom_range(0, 255));
            end
            else if (style == 2)
            begin
                len = $urandom_range(1, seq.size());
                while (seq.size() > len)
                    void'(seq.pop_back());
            end
        end

        for (int i = 0; i < seq.size(); i++)
            send_char(seq[i], i == seq.size() - 1, -1, '0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls on ready, and every request taken is checked
    // field by field against the oldest outstanding prediction.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int      stall_left;
        result_t want;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d char %h halted %0d last %0d",
                             $time, result_bus.kind, result_bus.out_char,
                             result_bus.halted, result_bus.last_of_run);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bus.kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d, actual %0d",
                                 $time, want.kind, result_bus.kind);
                        mismatch_count++;
                    end
                    if (result_bus.out_char !== want.out_char)
                    begin
                        $display("%0t: out_char expected %h, actual %h",
                                 $time, want.out_char, result_bus.out_char);
                        mismatch_count++;
                    end
                    if (result_bus.halted !== want.halted)
                    begin
                        $display("%0t: halted expected %0d, actual %0d",
                                 $time, want.halted, result_bus.halted);
                        mismatch_count++;
                    end
                    if (result_bus.last_of_run !== want.last_of_run)
                    begin
                        $display("%0t: last_of_run expected %0d, actual %0d",
                                 $time, want.last_of_run, result_bus.last_of_run);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: directed table, random values, then the final drain.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int value_count;
        value_count           = 0;
        item_bus.valid        <= 1'b0;
        item_bus.ch           <= 8'h00;
        item_bus.end_of_value <= 1'b0;

        // Right after reset a NUL halts silently and the next end of value
        // reports the halt; the rows that follow walk every parse state,
        // both quote styles, an escaped quote, the class extremes and a
        // final character that produces a value, a flush and a done.
        dir_tab[0]  = dir_row(8'h00, 1'b0, 0, '0);
        dir_tab[1]  = dir_row(8'hFF, 1'b1, 1, mk_result(KIND_DONE, 8'h00, 1'b1, 1'b1));
        dir_tab[2]  = dir_row("t", 1'b0, 1, mk_result(KIND_MAJOR, "t", 1'b0, 1'b1));
        dir_tab[3]  = dir_row(8'h7E, 1'b0, -1, '0);
        dir_tab[4]  = dir_row(8'h21, 1'b0, -1, '0);
        dir_tab[5]  = dir_row(8'h09, 1'b0, -1, '0);
        dir_tab[6]  = dir_row(CH_SEMI, 1'b0, -1, '0);
        dir_tab[7]  = dir_row(CH_USCORE, 1'b0, -1, '0);
        dir_tab[8]  = dir_row(CH_DOT, 1'b0, -1, '0);
        dir_tab[9]  = dir_row(CH_DASH, 1'b0, -1, '0);
        dir_tab[10] = dir_row(8'h0D, 1'b0, -1, '0);
        dir_tab[11] = dir_row(CH_EQ, 1'b0, -1, '0);
        dir_tab[12] = dir_row(CH_DQUOTE, 1'b0, -1, '0);
        dir_tab[13] = dir_row(CH_BSLASH, 1'b0, -1, '0);
        dir_tab[14] = dir_row(CH_DQUOTE, 1'b0, -1, '0);
        dir_tab[15] = dir_row(CH_SQUOTE, 1'b0, -1, '0);
        dir_tab[16] = dir_row(CH_DQUOTE, 1'b0, -1, '0);
        dir_tab[17] = dir_row("Z", 1'b0, -1, '0);
        dir_tab[18] = dir_row(CH_EQ, 1'b0, -1, '0);
        dir_tab[19] = dir_row(CH_SQUOTE, 1'b0, -1, '0);
        dir_tab[20] = dir_row(8'h80, 1'b0, -1, '0);
        dir_tab[21] = dir_row(CH_BSLASH, 1'b1, -1, '0);
        dir_tab[22] = dir_row(CH_SEMI, 1'b0, -1, '0);
        dir_tab[23] = dir_row("k", 1'b0, -1, '0);
        dir_tab[24] = dir_row(CH_EQ, 1'b0, -1, '0);
        dir_tab[25] = dir_row("v", 1'b1, -1, '0);

        @(posedge rst_n);
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_char(dir_tab[i].c, dir_tab[i].eov, dir_tab[i].n_typed, dir_tab[i].typed_res);

        // Let the directed results all come home before the random part.
        wait_drained();

        while (active_chars < TARGET_CHARS)
        begin
            // Now and then a whole value runs with no idling on either side.
            steady_flow = ($urandom_range(0, 4) == 0);
            send_header_value();
            value_count++;
            if (value_count % 5 == 0)
                wait_drained();
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with the longest stalls.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : tb_content_type_header_parser

// ===== content_type_header_parser.f =====
hdl/ctp_pkg.sv
hdl/ctp_in_if.sv
hdl/ctp_out_if.sv
hdl/ctp_parser.sv
hdl/ctp_resq.sv
hdl/content_type_header_parser.sv
verif/tb_content_type_header_parser.sv
